[rtl/core/two_path_smooth_wrr_scheduler_defines.svh]
// Assertion macros shared by the checker of the two-path scheduler.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef TWO_PATH_SMOOTH_WRR_SCHEDULER_DEFINES_SVH
`define TWO_PATH_SMOOTH_WRR_SCHEDULER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPSWRR_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TPSWRR_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tpswrr_pkg.sv]
// Package of the two-path smooth weighted round robin scheduler.
// Holds field widths, register indexes, reset values and the control structs.
// No dependencies.
package tpswrr_pkg;

  // Default fraction width of the weights.
  localparam int FRAC_BITS_DEF = 16;

  // Field and port widths.
  localparam int SHARE_W    = 17;
  localparam int MTU_W      = 16;
  localparam int EPOCH_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SHARE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MTU_EN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MTU0   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MTU1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EPOCH  = 3'd4;

  // Register reset values.
  localparam logic [SHARE_W-1:0] SHARE_RST = 17'd32768;
  localparam logic [MTU_W-1:0]   MTU_RST   = 16'd1500;
  localparam logic [EPOCH_W-1:0] EPOCH_RST = 32'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_prod;   // register the two share-times-MTU products
    logic div_init;    // load divider remainder and divisor
    logic div_step;    // one quotient bit
    logic load_plain;  // effective weights from the unscaled share
    logic load_div;    // effective weights from the quotient
    logic do_step;     // one round robin choice into the output register
    logic clear_cur;   // the choice starts from cleared current weights
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic use_div;     // MTU weighting on and divisor not zero
  } stat_t;

endpackage

[rtl/core/tpswrr_ctrl.sv]
// Controller of the two-path scheduler: input and output handshake,
// recompute sequencing and divider iteration count. Uses tpswrr_pkg.
module tpswrr_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_restart,
  output logic                 in_tready,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  input  tpswrr_pkg::stat_t    stat_i,
  output tpswrr_pkg::cmd_t     cmd_o
);
  import tpswrr_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_STEP = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               pending_r, pending_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free;
  logic               accept;

  // The output register can take a new word when empty or being drained.
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE) && out_free;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    pending_nxt = pending_r;
    cmd_o       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_restart || pending_r) begin
            cmd_o.load_prod = 1'b1;
            pending_nxt     = 1'b0;
            state_nxt       = ST_MUL;
          end else begin
            cmd_o.do_step = 1'b1;
          end
        end
      end
      ST_MUL: begin
        if (stat_i.use_div) begin
          cmd_o.div_init = 1'b1;
          cnt_nxt        = '0;
          state_nxt      = ST_DIV;
        end else begin
          cmd_o.load_plain = 1'b1;
          state_nxt        = ST_STEP;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_r == CNT_W'(FRAC_BITS)) begin
          cmd_o.load_div = 1'b1;
          state_nxt      = ST_STEP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_STEP: begin
        if (out_free) begin
          cmd_o.do_step   = 1'b1;
          cmd_o.clear_cur = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid follows a choice and clears when the word is taken.
  always_comb begin
    if (cmd_o.do_step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pending_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/tpswrr_dp.sv]
// Datapath of the two-path scheduler: configuration registers, product
// registers, restoring divider, weights and output word. Uses tpswrr_pkg.
module tpswrr_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we_i,
  input  logic [tpswrr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tpswrr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  tpswrr_pkg::cmd_t                    cmd_i,
  output tpswrr_pkg::stat_t                   stat_o,
  output logic                                path_o,
  output logic [tpswrr_pkg::EPOCH_W-1:0]      epoch_o
);
  import tpswrr_pkg::*;

  localparam int EW = FRAC_BITS + 1;                  // effective weight, quotient
  localparam int CW = FRAC_BITS + 3;                  // signed current weight
  localparam int MW = (SHARE_W > EW) ? SHARE_W : EW;  // share compare width
  localparam int PW = EW + MTU_W;                     // product width
  localparam int DW = PW + 1;                         // divisor width
  localparam int RW = DW + 1;                         // remainder width
  localparam logic [EW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [SHARE_W-1:0]    share_r;
  logic                  mtu_en_r;
  logic [MTU_W-1:0]      mtu0_r, mtu1_r;
  logic [EPOCH_W-1:0]    epoch_r;

  logic [EW-1:0]         x;
  logic [PW-1:0]         p1_r, p2_r;
  logic [DW-1:0]         den;
  logic [DW-1:0]         den_r;
  logic [RW-1:0]         rem_r, rem_nxt, rem_sub;
  logic [EW-1:0]         q_r, q_nxt;
  logic                  ge;
  logic [EW-1:0]         eff0_r, eff1_r;
  logic signed [CW-1:0]  cur0_r, cur1_r;
  logic signed [CW-1:0]  e0_s, e1_s, a0, a1, one_s;
  logic                  sel;
  logic                  path_r;
  logic [EPOCH_W-1:0]    epoch_out_r;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      share_r  <= SHARE_RST;
      mtu_en_r <= 1'b0;
      mtu0_r   <= MTU_RST;
      mtu1_r   <= MTU_RST;
      epoch_r  <= EPOCH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SHARE:  share_r  <= cfg_data_i[SHARE_W-1:0];
        CFG_MTU_EN: mtu_en_r <= cfg_data_i[0];
        CFG_MTU0:   mtu0_r   <= cfg_data_i[MTU_W-1:0];
        CFG_MTU1:   mtu1_r   <= cfg_data_i[MTU_W-1:0];
        CFG_EPOCH:  epoch_r  <= cfg_data_i[EPOCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Share saturated to one unit.
  assign x = (MW'(share_r) > MW'(ONE)) ? ONE : EW'(MW'(share_r));

  // Products of the share terms and the MTUs.
  always_ff @(posedge clk) begin
    if (cmd_i.load_prod) begin
      p1_r <= PW'(x) * PW'(mtu1_r);
      p2_r <= PW'(ONE - x) * PW'(mtu0_r);
    end
  end

  assign den            = DW'(p1_r) + DW'(p2_r);
  assign stat_o.use_div = mtu_en_r && (den != '0);

  // Restoring division, one quotient bit a cycle, most significant first.
  assign ge      = rem_r >= RW'(den_r);
  assign rem_sub = ge ? (rem_r - RW'(den_r)) : rem_r;
  assign rem_nxt = rem_sub << 1;
  assign q_nxt   = {q_r[EW-2:0], ge};

  always_ff @(posedge clk) begin
    if (cmd_i.div_init) begin
      rem_r <= RW'(p1_r);
      den_r <= den;
      q_r   <= '0;
    end else if (cmd_i.div_step) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  // Round robin choice; path 0 wins ties.
  assign e0_s  = $signed(CW'(eff0_r));
  assign e1_s  = $signed(CW'(eff1_r));
  assign one_s = $signed(CW'(ONE));
  assign a0    = cmd_i.clear_cur ? e0_s : (cur0_r + e0_s);
  assign a1    = cmd_i.clear_cur ? e1_s : (cur1_r + e1_s);
  assign sel   = a1 > a0;

  // Weights.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff0_r <= '0;
      eff1_r <= '0;
      cur0_r <= '0;
      cur1_r <= '0;
    end else begin
      if (cmd_i.load_plain) begin
        eff0_r <= x;
        eff1_r <= ONE - x;
      end else if (cmd_i.load_div) begin
        eff0_r <= q_nxt;
        eff1_r <= ONE - q_nxt;
      end
      if (cmd_i.do_step) begin
        cur0_r <= sel ? a0 : (a0 - one_s);
        cur1_r <= sel ? (a1 - one_s) : a1;
      end
    end
  end

  // Output word.
  always_ff @(posedge clk) begin
    if (cmd_i.do_step) begin
      path_r      <= sel;
      epoch_out_r <= epoch_r;
    end
  end

  assign path_o  = path_r;
  assign epoch_o = epoch_out_r;

endmodule

[rtl/core/two_path_smooth_wrr_scheduler.sv]
// Top level of the two-path smooth weighted round robin scheduler.
// Instantiates tpswrr_ctrl and tpswrr_dp; uses tpswrr_pkg.
//
// Each word on the in_ stream is one send request; each word on the out_
// stream is the path chosen for it together with the epoch register.
// Registers are written over the cfg_ port, which is always ready; new
// share and MTU values take effect at the next recompute, the epoch at the
// next choice. A request without restart gives its result in the cycle
// after acceptance, and such requests are taken one per cycle as long as
// the receiver keeps up. The first request after reset and every request
// with restart set recompute the effective weights: the products are
// registered, then the weights load from the unscaled share without MTU
// weighting or with a zero divisor, else from the restoring divider that
// forms one quotient bit per cycle. No request is taken during a recompute.
// The output register holds its word while out_tready is low; a new
// request is accepted in the cycle the held word is taken.
// Reset (rst_n low, synchronous) restores the register defaults, clears
// the weights and marks the weights for recompute on the first request.
module two_path_smooth_wrr_scheduler #(
  parameter int FRAC_BITS = tpswrr_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tpswrr_pkg::IN_DATA_W-1:0]    in_tdata,    // [0] restart
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tpswrr_pkg::OUT_DATA_W-1:0]   out_tdata,   // [0] path, [32:1] epoch_out
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tpswrr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tpswrr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tpswrr_pkg::*;

  cmd_t                cmd;
  stat_t               stat;
  logic                path;
  logic [EPOCH_W-1:0]  epoch_out;

  assign cfg_ready = 1'b1;

  tpswrr_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_restart (in_tdata[0]),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tpswrr_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we_i    (cfg_valid && cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .path_o      (path),
    .epoch_o     (epoch_out)
  );

  // Pack the result word, zero padded to whole bytes.
  assign out_tdata = OUT_DATA_W'({epoch_out, path});

endmodule

[rtl/core/tpswrr_checker.sv]
// Port-level checker of the two-path scheduler, bound to the top level.
// Uses tpswrr_pkg and the macros of two_path_smooth_wrr_scheduler_defines.svh.
`include "two_path_smooth_wrr_scheduler_defines.svh"

module tpswrr_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [tpswrr_pkg::IN_DATA_W-1:0]    in_tdata,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [tpswrr_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import tpswrr_pkg::*;

  logic out_stall;
  logic out_room;
  logic restart_acc;

  // Handshake conditions the assertions are written on.
  assign out_stall   = out_tvalid && !out_tready;
  assign out_room    = !out_tvalid || out_tready;
  assign restart_acc = in_tvalid && in_tready && in_tdata[0];

  // A held result word keeps its value until it is taken.
  `TPSWRR_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata), "held word changed")

  // A request is only taken when the output register has room for its result.
  `TPSWRR_ASSERT_NOW(a_ready_room, in_tready, out_room, "request taken with output register full")

  // A taken restart request starts a recompute, so in_tready must drop right after it.
  `TPSWRR_ASSERT_NEXT(a_restart_busy, restart_acc, !in_tready, "request taken during recompute")

endmodule

bind two_path_smooth_wrr_scheduler tpswrr_checker u_checker (.*);
